@@ design/rlcdt_pkg.sv @@
// shared constants, register codes and beat types for the ruled-line drift tracker
`timescale 1ns / 1ps
`default_nettype none

package rlcdt_pkg;

  // column geometry and field widths
  localparam int MAX_ROWS = 128;
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 7;
  localparam int CNT_W    = 8;
  localparam int OFS_W    = 16;
  localparam int RROW_W   = 8;

  // row cap in the width of the row-count register
  localparam logic [CNT_W-1:0] MAX_ROWS_CAP = CNT_W'(MAX_ROWS);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 3'd4;

  // reset values of the configuration registers
  localparam logic [ROW_W-1:0] TEXT_TOP_RST    = 7'd0;
  localparam logic [ROW_W-1:0] TEXT_BOTTOM_RST = 7'd127;
  localparam logic [ROW_W-1:0] LINE_GAP_RST    = 7'd7;
  localparam logic [PIX_W-1:0] TEXT_LEVEL_RST  = 8'd255;
  localparam logic [CNT_W-1:0] ROWS_IN_USE_RST = 8'd128;

  // row marker for "no ruled line found"
  localparam logic signed [RROW_W-1:0] ROW_NONE = -8'sd1;

  typedef struct packed {
    logic [ROW_W-1:0] text_top;
    logic [ROW_W-1:0] text_bottom;
    logic [ROW_W-1:0] line_gap;
    logic [PIX_W-1:0] text_level;
    logic [CNT_W-1:0] rows_in_use;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ROW_W-1:0] row;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic signed [OFS_W-1:0]  column_offset;
    logic signed [RROW_W-1:0] upper_row;
    logic signed [RROW_W-1:0] lower_row;
    logic                     saturated;
  } result_t;

endpackage

`default_nettype wire

@@ design/rlcdt_cfg_regs.sv @@
// configuration register file written through the cfg channel
`timescale 1ns / 1ps
`default_nettype none

module rlcdt_cfg_regs
  import rlcdt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // index decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEXT_TOP:    cfg_nxt.text_top    = cfg_data[ROW_W-1:0];
        CFG_TEXT_BOTTOM: cfg_nxt.text_bottom = cfg_data[ROW_W-1:0];
        CFG_LINE_GAP:    cfg_nxt.line_gap    = cfg_data[ROW_W-1:0];
        CFG_TEXT_LEVEL:  cfg_nxt.text_level  = cfg_data[PIX_W-1:0];
        CFG_ROWS_IN_USE: cfg_nxt.rows_in_use = cfg_data[CNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_top    <= TEXT_TOP_RST;
      cfg_r.text_bottom <= TEXT_BOTTOM_RST;
      cfg_r.line_gap    <= LINE_GAP_RST;
      cfg_r.text_level  <= TEXT_LEVEL_RST;
      cfg_r.rows_in_use <= ROWS_IN_USE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/rlcdt_engine.sv @@
// per-pixel line search, column-end offset update and tracker state
`timescale 1ns / 1ps
`default_nettype none

module rlcdt_engine
  import rlcdt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire logic    pix_fire,
  input  wire pix_t    pix,
  output logic         has_result,
  output result_t      result
);

  logic signed [OFS_W-1:0]  offset_r,     offset_nxt;
  logic signed [RROW_W-1:0] prev_upper_r, prev_upper_nxt;
  logic signed [RROW_W-1:0] prev_lower_r, prev_lower_nxt;
  logic signed [RROW_W-1:0] cur_upper_r,  cur_upper_nxt;
  logic signed [RROW_W-1:0] cur_lower_r,  cur_lower_nxt;

  logic [CNT_W-1:0]         rows_eff;
  logic [CNT_W-1:0]         row_ext;
  logic                     in_range;
  logic                     is_last;
  logic                     ink;
  logic                     upper_hit;
  logic                     lower_hit;
  logic signed [OFS_W-1:0]  offset_b;
  logic signed [RROW_W-1:0] prev_upper_b, prev_lower_b, cur_upper_b, cur_lower_b;
  logic signed [RROW_W-1:0] cur_upper_n, cur_lower_n;
  logic signed [RROW_W:0]   delta;
  logic signed [OFS_W:0]    sum;
  logic                     sat;
  logic signed [OFS_W-1:0]  sum_clip;

  // row window and column end
  always_comb begin
    rows_eff = (cfg.rows_in_use > MAX_ROWS_CAP) ? MAX_ROWS_CAP : cfg.rows_in_use;
    row_ext  = {1'b0, pix.row};
    in_range = row_ext < rows_eff;
    is_last  = in_range && (row_ext == rows_eff - CNT_W'(1));
  end

  // frame start clears offset and rows before the pixel is looked at
  always_comb begin
    offset_b     = pix.frame_start ? '0       : offset_r;
    prev_upper_b = pix.frame_start ? ROW_NONE : prev_upper_r;
    prev_lower_b = pix.frame_start ? ROW_NONE : prev_lower_r;
    cur_upper_b  = pix.frame_start ? ROW_NONE : cur_upper_r;
    cur_lower_b  = pix.frame_start ? ROW_NONE : cur_lower_r;
  end

  // ink match against both search windows
  always_comb begin
    ink       = in_range && (pix.pixel == cfg.text_level);
    upper_hit = ink && ((row_ext + {1'b0, cfg.line_gap}) <= {1'b0, cfg.text_top});
    lower_hit = ink && (row_ext >= ({1'b0, cfg.text_bottom} + {1'b0, cfg.line_gap}))
                && cur_lower_b[RROW_W-1];
    cur_upper_n = upper_hit ? $signed({1'b0, pix.row}) : cur_upper_b;
    cur_lower_n = lower_hit ? $signed({1'b0, pix.row}) : cur_lower_b;
  end

  // drift step: upper line first, lower line as fallback
  always_comb begin
    if (!prev_upper_b[RROW_W-1] && !cur_upper_n[RROW_W-1]) begin
      delta = $signed({cur_upper_n[RROW_W-1], cur_upper_n})
            - $signed({prev_upper_b[RROW_W-1], prev_upper_b});
    end else if (!prev_lower_b[RROW_W-1] && !cur_lower_n[RROW_W-1]) begin
      delta = $signed({cur_lower_n[RROW_W-1], cur_lower_n})
            - $signed({prev_lower_b[RROW_W-1], prev_lower_b});
    end else begin
      delta = '0;
    end
    sum = $signed({offset_b[OFS_W-1], offset_b})
        + $signed({{(OFS_W-RROW_W){delta[RROW_W]}}, delta});
    sat = sum[OFS_W] != sum[OFS_W-1];
    if (!sat) begin
      sum_clip = sum[OFS_W-1:0];
    end else if (sum[OFS_W]) begin
      sum_clip = {1'b1, {(OFS_W-1){1'b0}}};
    end else begin
      sum_clip = {1'b0, {(OFS_W-1){1'b1}}};
    end
  end

  // state update on every accepted pixel
  always_comb begin
    offset_nxt     = offset_r;
    prev_upper_nxt = prev_upper_r;
    prev_lower_nxt = prev_lower_r;
    cur_upper_nxt  = cur_upper_r;
    cur_lower_nxt  = cur_lower_r;
    if (pix_fire) begin
      if (is_last) begin
        offset_nxt     = sum_clip;
        prev_upper_nxt = cur_upper_n;
        prev_lower_nxt = cur_lower_n;
        cur_upper_nxt  = ROW_NONE;
        cur_lower_nxt  = ROW_NONE;
      end else begin
        offset_nxt     = offset_b;
        prev_upper_nxt = prev_upper_b;
        prev_lower_nxt = prev_lower_b;
        cur_upper_nxt  = cur_upper_n;
        cur_lower_nxt  = cur_lower_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      prev_upper_r <= ROW_NONE;
      prev_lower_r <= ROW_NONE;
      cur_upper_r  <= ROW_NONE;
      cur_lower_r  <= ROW_NONE;
    end else begin
      offset_r     <= offset_nxt;
      prev_upper_r <= prev_upper_nxt;
      prev_lower_r <= prev_lower_nxt;
      cur_upper_r  <= cur_upper_nxt;
      cur_lower_r  <= cur_lower_nxt;
    end
  end

  // column result
  assign has_result           = is_last;
  assign result.column_offset = sum_clip;
  assign result.upper_row     = cur_upper_n;
  assign result.lower_row     = cur_lower_n;
  assign result.saturated     = sat;

endmodule

`default_nettype wire

@@ design/ruled_line_column_drift_tracker_core.sv @@
// top level of the ruled-line column drift tracker: beat registers and channels
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel beat per clock, top row first, column by column, and gives one
// result beat at the last row of each column (row equal to rows_in_use - 1, with
// rows_in_use capped at 128). A result holds the running vertical offset, the
// upper and lower ruled-line rows of the column (-1 when none) and a saturation
// flag. An input beat is held in the input register, then the search and
// offset update feed the result register. The tracker state moves on once per
// pixel, so the sustained rate is one pixel per clock as long as results are
// taken. Pixels at or beyond the row count give no result; in_tuser marks the
// first pixel of a frame and clears the offset and the stored rows.
// Configuration writes take effect at once and belong in idle periods only;
// cfg_ready is always high.
module ruled_line_column_drift_tracker_core
  import rlcdt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // pixel stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [15:0]          in_tdata,   // pixel[7:0], row[14:8], zero[15]
  input  wire logic                 in_tuser,   // frame_start
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [39:0]               out_tdata,  // column_offset[15:0], upper_row[23:16],
                                                // lower_row[31:24], saturated[32], zero[39:33]
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t    cfg;
  pix_t    pix_r, pix_nxt;
  logic    pix_vld_r, pix_vld_nxt;
  result_t res_r, res_nxt;
  logic    res_vld_r, res_vld_nxt;
  result_t eng_res;
  logic    eng_has_res;
  logic    out_free;
  logic    pix_adv;
  logic    in_beat;

  assign cfg_ready = 1'b1;

  rlcdt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // beat flow between input register and result register
  assign out_free  = !res_vld_r || out_tready;
  assign pix_adv   = pix_vld_r && out_free;
  assign in_tready = !pix_vld_r || pix_adv;
  assign in_beat   = in_tvalid && in_tready;

  rlcdt_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .pix_fire   (pix_adv),
    .pix        (pix_r),
    .has_result (eng_has_res),
    .result     (eng_res)
  );

  // input register
  always_comb begin
    pix_nxt     = pix_r;
    pix_vld_nxt = pix_vld_r;
    if (in_beat) begin
      pix_nxt.pixel       = in_tdata[PIX_W-1:0];
      pix_nxt.row         = in_tdata[PIX_W+ROW_W-1:PIX_W];
      pix_nxt.frame_start = in_tuser;
      pix_vld_nxt         = 1'b1;
    end else if (pix_adv) begin
      pix_vld_nxt = 1'b0;
    end
  end

  // result register
  always_comb begin
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r;
    if (pix_adv && eng_has_res) begin
      res_nxt     = eng_res;
      res_vld_nxt = 1'b1;
    end else if (out_tready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      pix_vld_r <= pix_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {7'd0, res_r.saturated, res_r.lower_row, res_r.upper_row,
                       res_r.column_offset};

endmodule

`default_nettype wire

@@ test/drift_checker.sv @@
// beat monitor, column drift predictor and result comparison for the ruled-line tracker
`timescale 1ns / 1ps

module drift_checker
  import rlcdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [15:0]          in_tdata,   // pixel[7:0], row[14:8], zero[15]
  input  logic                 in_tuser,   // frame_start
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [39:0]          out_tdata,  // column_offset[15:0], upper_row[23:16],
                                           // lower_row[31:24], saturated[32], zero[39:33]
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   pending,
  output int                   mismatches,
  output int                   columns_done
);

  localparam int OFS_HI = 2 ** (OFS_W - 1) - 1;
  localparam int OFS_LO = -(2 ** (OFS_W - 1));

  // shadow of the configuration registers
  logic [ROW_W-1:0] band_top;
  logic [ROW_W-1:0] band_bottom;
  logic [ROW_W-1:0] search_gap;
  logic [PIX_W-1:0] ink_level;
  logic [CNT_W-1:0] row_count;

  // tracker state
  logic signed [OFS_W-1:0]  drift;
  logic signed [RROW_W-1:0] last_upper;
  logic signed [RROW_W-1:0] last_lower;
  logic signed [RROW_W-1:0] this_upper;
  logic signed [RROW_W-1:0] this_lower;

  result_t expected_columns[$];

  // search one pixel and close the column on its last row
  task automatic track_pixel(input pix_t beat);
    int      rows;
    int      delta;
    int      total;
    result_t col;
    rows = (int'(row_count) > MAX_ROWS) ? MAX_ROWS : int'(row_count);
    if (beat.frame_start) begin
      drift      = '0;
      last_upper = ROW_NONE;
      last_lower = ROW_NONE;
      this_upper = ROW_NONE;
      this_lower = ROW_NONE;
    end
    if (int'(beat.row) >= rows) return;
    if (beat.pixel == ink_level) begin
      if (int'(beat.row) + int'(search_gap) <= int'(band_top))
        this_upper = signed'({1'b0, beat.row});
      if (int'(beat.row) >= int'(band_bottom) + int'(search_gap) && this_lower < 0)
        this_lower = signed'({1'b0, beat.row});
    end
    if (int'(beat.row) != rows - 1) return;
    // upper line drift first, lower line as fallback
    delta = 0;
    if (last_upper >= 0 && this_upper >= 0)
      delta = int'(this_upper) - int'(last_upper);
    else if (last_lower >= 0 && this_lower >= 0)
      delta = int'(this_lower) - int'(last_lower);
    total = int'(drift) + delta;
    col.saturated = 1'b0;
    if (total > OFS_HI) begin
      total = OFS_HI;
      col.saturated = 1'b1;
    end else if (total < OFS_LO) begin
      total = OFS_LO;
      col.saturated = 1'b1;
    end
    drift             = OFS_W'(total);
    col.column_offset = drift;
    col.upper_row     = this_upper;
    col.lower_row     = this_lower;
    expected_columns.push_back(col);
    last_upper = this_upper;
    last_lower = this_lower;
    this_upper = ROW_NONE;
    this_lower = ROW_NONE;
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      band_top    = TEXT_TOP_RST;
      band_bottom = TEXT_BOTTOM_RST;
      search_gap  = LINE_GAP_RST;
      ink_level   = TEXT_LEVEL_RST;
      row_count   = ROWS_IN_USE_RST;
      drift       = '0;
      last_upper  = ROW_NONE;
      last_lower  = ROW_NONE;
      this_upper  = ROW_NONE;
      this_lower  = ROW_NONE;
      expected_columns.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEXT_TOP:    band_top    = cfg_data[ROW_W-1:0];
          CFG_TEXT_BOTTOM: band_bottom = cfg_data[ROW_W-1:0];
          CFG_LINE_GAP:    search_gap  = cfg_data[ROW_W-1:0];
          CFG_TEXT_LEVEL:  ink_level   = cfg_data;
          CFG_ROWS_IN_USE: row_count   = cfg_data;
          default: ;
        endcase
      end
      // pixel beats
      if (in_tvalid && in_tready)
        track_pixel('{pixel: in_tdata[7:0], row: in_tdata[14:8], frame_start: in_tuser});
      // result beats
      if (out_tvalid && out_tready) begin
        got.column_offset = out_tdata[15:0];
        got.upper_row     = out_tdata[23:16];
        got.lower_row     = out_tdata[31:24];
        got.saturated     = out_tdata[32];
        if (expected_columns.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got offset %0d upper %0d lower %0d sat %0d",
                   $time, got.column_offset, got.upper_row, got.lower_row, got.saturated);
        end else begin
          want = expected_columns.pop_front();
          columns_done++;
          check_field("column_offset", int'(want.column_offset), int'(got.column_offset));
          check_field("upper_row", int'(want.upper_row), int'(got.upper_row));
          check_field("lower_row", int'(want.lower_row), int'(got.lower_row));
          check_field("saturated", int'(want.saturated), int'(got.saturated));
        end
      end
    end
    pending <= expected_columns.size();
  end

endmodule

@@ test/tb_top.sv @@
// stimulus, clock, reset and verdict for the ruled-line column drift tracker
`timescale 1ns / 1ps

module tb_top;
  import rlcdt_pkg::*;

  localparam int IDLE_PCT      = 18;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 500;
  localparam int DRIFT_LOOPS   = 270;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // pixel[7:0], row[14:8], zero[15]
  logic                 in_tuser   = 1'b0; // frame_start
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;         // column_offset[15:0], upper_row[23:16],
                                           // lower_row[31:24], saturated[32], zero[39:33]
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_data   = '0;

  int pending;
  int mismatches;
  int columns_done;

  // stimulus bookkeeping
  logic       steady = 1'b0;
  logic [7:0] ink_now = TEXT_LEVEL_RST;
  int         rows_eff = MAX_ROWS;
  int         beats_sent;
  int         in_range_beats;
  int         settings;

  ruled_line_column_drift_tracker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  drift_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .mismatches   (mismatches),
    .columns_done (columns_done)
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // one pixel beat; valid stays up afterwards until the next gap or drain
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [ROW_W-1:0] row,
                            input logic fs);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, row, pix};
    in_tuser  <= fs;
    if (int'(row) < rows_eff) in_range_beats++;
    beats_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the pixel stream until every column result is out and the pipe is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // spare top bit of the 7-bit registers is random, it must be dropped
  task automatic configure(input int top, input int bottom, input int gap,
                           input int level, input int rows);
    drain();
    write_reg(CFG_TEXT_TOP, {1'($urandom), 7'(top)});
    write_reg(CFG_TEXT_BOTTOM, {1'($urandom), 7'(bottom)});
    write_reg(CFG_LINE_GAP, {1'($urandom), 7'(gap)});
    write_reg(CFG_TEXT_LEVEL, 8'(level));
    write_reg(CFG_ROWS_IN_USE, 8'(rows));
    ink_now  = 8'(level);
    rows_eff = (rows > MAX_ROWS) ? MAX_ROWS : rows;
    settings++;
  endtask

  // well-formed column, rows in order, a few rows left out
  task automatic send_column(input logic fs, input int ink_pct);
    logic [PIX_W-1:0] pix;
    for (int r = 0; r < rows_eff; r++) begin
      pix = ($urandom_range(99) < ink_pct) ? ink_now : 8'($urandom);
      if (r == rows_eff - 1 || $urandom_range(99) >= 8)
        send_pixel(pix, 7'(r), fs && r == 0);
    end
  endtask

  // rows in any order, some past the row count, the odd frame mark
  task automatic send_noise(input int n);
    repeat (n)
      send_pixel(($urandom_range(99) < 40) ? ink_now : 8'($urandom), 7'($urandom),
                 $urandom_range(99) < 5);
  endtask

  initial begin
    int sel;
    int rows;
    int span;
    int top;
    int bottom;
    int gap;
    int level;
    int ncols;
    int start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // an unused register index must change nothing
    write_reg(CFG_UNUSED, 8'hFF);

    // reset settings: both searches empty, full 128-row columns
    send_pixel(8'd255, 7'd127, 1'b1);
    send_pixel(8'd0, 7'd0, 1'b0);
    send_pixel(8'd255, 7'd126, 1'b0);
    send_pixel(8'd255, 7'd127, 1'b0);

    // upper band rows 0..8, lower band rows 22..23
    configure(10, 20, 2, 0, 24);
    send_pixel(8'd0, 7'd3, 1'b1);
    send_pixel(8'd0, 7'd5, 1'b0);
    send_pixel(8'd0, 7'd23, 1'b0);
    // upper is the last hit, lower the first hit, rows out of order
    send_pixel(8'd0, 7'd8, 1'b0);
    send_pixel(8'd0, 7'd2, 1'b0);
    send_pixel(8'd0, 7'd22, 1'b0);
    send_pixel(8'd0, 7'd23, 1'b0);
    // column with no line, then lower only, then lower drift
    send_pixel(8'd7, 7'd23, 1'b0);
    send_pixel(8'd0, 7'd23, 1'b0);
    send_pixel(8'd0, 7'd22, 1'b0);
    send_pixel(8'd0, 7'd23, 1'b0);
    // row past the count is ignored, but its frame mark still clears the state
    send_pixel(8'd0, 7'd100, 1'b0);
    send_pixel(8'd0, 7'd127, 1'b1);
    send_pixel(8'd0, 7'd23, 1'b0);

    // zero row count ignores everything, an oversized one is capped
    configure(127, 0, 0, 255, 0);
    send_pixel(8'd255, 7'd0, 1'b0);
    send_pixel(8'd255, 7'd127, 1'b0);
    configure(127, 0, 0, 255, 200);
    send_pixel(8'd255, 7'd5, 1'b0);
    send_pixel(8'd255, 7'd127, 1'b0);

    // drive the offset into the positive bound with no idling on either side
    configure(127, 127, 0, 255, MAX_ROWS);
    steady = 1'b1;
    for (int i = 0; i < DRIFT_LOOPS; i++) begin
      send_pixel(8'd255, 7'd0, i == 0);
      send_pixel(8'($urandom_range(254)), 7'd127, 1'b0);
      send_pixel(8'd255, 7'd127, 1'b0);
      send_pixel(8'($urandom_range(254)), 7'd127, 1'b0);
    end
    steady = 1'b0;
    // and from a fresh frame into the negative bound
    send_pixel(8'($urandom_range(254)), 7'd127, 1'b1);
    for (int i = 0; i < DRIFT_LOOPS; i++) begin
      send_pixel(8'd255, 7'd127, 1'b0);
      send_pixel(8'd255, 7'd0, 1'b0);
      send_pixel(8'($urandom_range(254)), 7'd127, 1'b0);
      send_pixel(8'($urandom_range(254)), 7'd127, 1'b0);
    end

    // random settings, mostly short columns
    start = in_range_beats;
    while (in_range_beats - start < RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 70) rows = $urandom_range(1, 16);
      else if (sel < 80) rows = MAX_ROWS;
      else if (sel < 87) rows = $urandom_range(17, 127);
      else if (sel < 93) rows = $urandom_range(129, 255);
      else rows = 0;
      span = (rows == 0) ? 3 : ((rows > MAX_ROWS ? MAX_ROWS : rows) + 2);
      if (span > 127) span = 127;
      if ($urandom_range(7) == 0) begin
        top    = $urandom_range(127);
        bottom = $urandom_range(127);
        gap    = (($urandom_range(1) == 0) ? 127 : $urandom_range(127));
      end else begin
        top    = $urandom_range(span);
        bottom = $urandom_range(span);
        gap    = $urandom_range(3);
      end
      sel = $urandom_range(9);
      level = (sel == 0) ? 0 : ((sel == 1) ? 255 : $urandom_range(255));
      configure(top, bottom, gap, level, rows);
      if (rows_eff == 0) begin
        send_noise(10);
      end else begin
        ncols = (rows_eff <= 16) ? $urandom_range(6, 20) : $urandom_range(1, 3);
        for (int c = 0; c < ncols; c++) begin
          if ($urandom_range(99) < 15)
            send_noise($urandom_range(1, 2 * rows_eff));
          else
            send_column((c == 0) ? 1'($urandom) : ($urandom_range(99) < 3),
                        $urandom_range(10, 50));
        end
      end
    end

    drain();
    $display("%0d pixel beats sent, %0d inside the row count, over %0d register settings",
             beats_sent, in_range_beats, settings);
    $display("%0d column results checked, offset taken to both saturation bounds",
             columns_done);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d results still outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
